// ===== src/adpe_pkg.sv =====
// Package: item types, field codes and shared structs for the data-processing execute block.
package adpe_pkg;

	// Input item: instruction word and its address
	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] instr_addr;
	} instr_item_t;

	// Result item
	typedef struct packed {
		logic        cond_passed;
		logic        reg_written;
		logic [3:0]  dest_reg;
		logic [31:0] alu_result;
		logic [3:0]  flags_out;
		logic        branch_taken;
	} result_item_t;

	// Register file write port
	typedef struct packed {
		logic        en;
		logic [3:0]  addr;
		logic [31:0] data;
	} rf_write_t;

	// ALU outcome for one instruction
	typedef struct packed {
		logic        passed;
		logic        compare;
		logic        flags_upd;
		logic [31:0] result;
		logic [3:0]  flags;
	} alu_out_t;

	localparam int RegCount = 15;
	localparam logic [3:0] RegPc = 4'd15;
	localparam logic [31:0] PcOffset = 32'd8;

	// Flag bit positions within NZCV
	localparam int FlagN = 3;
	localparam int FlagZ = 2;
	localparam int FlagC = 1;
	localparam int FlagV = 0;

	// Opcodes
	localparam logic [3:0] OpAnd = 4'd0;
	localparam logic [3:0] OpEor = 4'd1;
	localparam logic [3:0] OpSub = 4'd2;
	localparam logic [3:0] OpRsb = 4'd3;
	localparam logic [3:0] OpAdd = 4'd4;
	localparam logic [3:0] OpAdc = 4'd5;
	localparam logic [3:0] OpSbc = 4'd6;
	localparam logic [3:0] OpRsc = 4'd7;
	localparam logic [3:0] OpTst = 4'd8;
	localparam logic [3:0] OpTeq = 4'd9;
	localparam logic [3:0] OpCmp = 4'd10;
	localparam logic [3:0] OpCmn = 4'd11;
	localparam logic [3:0] OpOrr = 4'd12;
	localparam logic [3:0] OpMov = 4'd13;
	localparam logic [3:0] OpBic = 4'd14;
	localparam logic [3:0] OpMvn = 4'd15;

	// Condition codes
	localparam logic [3:0] CondEq = 4'd0;
	localparam logic [3:0] CondNe = 4'd1;
	localparam logic [3:0] CondCs = 4'd2;
	localparam logic [3:0] CondCc = 4'd3;
	localparam logic [3:0] CondMi = 4'd4;
	localparam logic [3:0] CondPl = 4'd5;
	localparam logic [3:0] CondVs = 4'd6;
	localparam logic [3:0] CondVc = 4'd7;
	localparam logic [3:0] CondHi = 4'd8;
	localparam logic [3:0] CondLs = 4'd9;
	localparam logic [3:0] CondGe = 4'd10;
	localparam logic [3:0] CondLt = 4'd11;
	localparam logic [3:0] CondGt = 4'd12;
	localparam logic [3:0] CondLe = 4'd13;

	// Shift types
	localparam logic [1:0] ShLsl = 2'd0;
	localparam logic [1:0] ShLsr = 2'd1;
	localparam logic [1:0] ShAsr = 2'd2;
	localparam logic [1:0] ShRor = 2'd3;

endpackage

// ===== src/adpe_regfile.sv =====
// Register file r0-r14: two array copies for three read ports, write bypass, valid bits.
module adpe_regfile (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [3:0]            rn_addr,
	input  logic [3:0]            rm_addr,
	input  logic [3:0]            rs_addr,
	input  adpe_pkg::rf_write_t   wr,
	output logic [31:0]           rn_data,
	output logic [31:0]           rm_data,
	output logic [31:0]           rs_data
);

	logic [31:0] mem_a_q [adpe_pkg::RegCount];
	logic [31:0] mem_b_q [adpe_pkg::RegCount];
	logic [adpe_pkg::RegCount-1:0] vld_q;
	logic [31:0] rn_q, rm_q, rs_q;

	// Write both copies
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_a_q[wr.addr] <= wr.data;
			mem_b_q[wr.addr] <= wr.data;
		end
	end

	// Entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// Registered reads with bypass of the write in the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rn_addr) begin
				rn_q <= wr.data;
			end else if (rn_addr != adpe_pkg::RegPc && vld_q[rn_addr]) begin
				rn_q <= mem_a_q[rn_addr];
			end else begin
				rn_q <= '0;
			end
			if (wr.en && wr.addr == rm_addr) begin
				rm_q <= wr.data;
			end else if (rm_addr != adpe_pkg::RegPc && vld_q[rm_addr]) begin
				rm_q <= mem_a_q[rm_addr];
			end else begin
				rm_q <= '0;
			end
			if (wr.en && wr.addr == rs_addr) begin
				rs_q <= wr.data;
			end else if (rs_addr != adpe_pkg::RegPc && vld_q[rs_addr]) begin
				rs_q <= mem_b_q[rs_addr];
			end else begin
				rs_q <= '0;
			end
		end
	end

	assign rn_data = rn_q;
	assign rm_data = rm_q;
	assign rs_data = rs_q;

endmodule

// ===== src/adpe_operand2.sv =====
// Second operand: rotated immediate or barrel-shifted register.
module adpe_operand2 (
	input  logic [31:0] instr_word,
	input  logic [31:0] rm_val,
	input  logic [31:0] rs_val,
	output logic [31:0] op2
);

	logic [4:0]  rot;
	logic [63:0] imm_dbl;
	logic [63:0] imm_rot;
	logic [7:0]  amt;
	logic        amt_big;
	logic [63:0] rm_dbl;
	logic [63:0] rm_rot;
	logic [31:0] sh_val;

	// Immediate: imm8 rotated right by twice the rotate field
	always_comb begin
		rot     = {instr_word[11:8], 1'b0};
		imm_dbl = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]};
		imm_rot = imm_dbl >> rot;
	end

	// Register operand through the barrel shifter
	always_comb begin
		amt     = instr_word[4] ? rs_val[7:0] : {3'd0, instr_word[11:7]};
		amt_big = |amt[7:5];
		rm_dbl  = {rm_val, rm_val};
		rm_rot  = rm_dbl >> amt[4:0];
		sh_val  = rm_val;
		if (amt != 8'd0) begin
			case (instr_word[6:5])
				adpe_pkg::ShLsl: sh_val = amt_big ? 32'd0 : (rm_val << amt[4:0]);
				adpe_pkg::ShLsr: sh_val = amt_big ? 32'd0 : (rm_val >> amt[4:0]);
				adpe_pkg::ShAsr: sh_val = amt_big ? {32{rm_val[31]}}
					: 32'($signed(rm_val) >>> amt[4:0]);
				adpe_pkg::ShRor: sh_val = rm_rot[31:0];
				default: sh_val = rm_val;
			endcase
		end
	end

	assign op2 = instr_word[25] ? imm_rot[31:0] : sh_val;

endmodule

// ===== src/adpe_alu.sv =====
// Condition check, 16-opcode ALU and NZCV generation.
module adpe_alu (
	input  logic [31:0]         instr_word,
	input  logic [31:0]         op1,
	input  logic [31:0]         op2,
	input  logic [3:0]          flags,
	output adpe_pkg::alu_out_t  res
);

	logic        n, z, c, v;
	logic        passed;
	logic [3:0]  opc;
	logic        arith, compare;
	logic [31:0] add_a, add_b, logic_res;
	logic        add_cin;
	logic [32:0] sum;
	logic [31:0] value;
	logic        ovf;
	logic [3:0]  new_flags;
	logic        upd;

	// Condition evaluation
	always_comb begin
		n = flags[adpe_pkg::FlagN];
		z = flags[adpe_pkg::FlagZ];
		c = flags[adpe_pkg::FlagC];
		v = flags[adpe_pkg::FlagV];
		case (instr_word[31:28])
			adpe_pkg::CondEq: passed = z;
			adpe_pkg::CondNe: passed = !z;
			adpe_pkg::CondCs: passed = c;
			adpe_pkg::CondCc: passed = !c;
			adpe_pkg::CondMi: passed = n;
			adpe_pkg::CondPl: passed = !n;
			adpe_pkg::CondVs: passed = v;
			adpe_pkg::CondVc: passed = !v;
			adpe_pkg::CondHi: passed = c && !z;
			adpe_pkg::CondLs: passed = !c || z;
			adpe_pkg::CondGe: passed = n == v;
			adpe_pkg::CondLt: passed = n != v;
			adpe_pkg::CondGt: passed = !z && (n == v);
			adpe_pkg::CondLe: passed = z || (n != v);
			default:          passed = 1'b1;
		endcase
	end

	// Operand selection for the shared adder and the logic unit
	always_comb begin
		opc       = instr_word[24:21];
		arith     = 1'b0;
		compare   = 1'b0;
		add_a     = op1;
		add_b     = ~op2;
		add_cin   = 1'b1;
		logic_res = '0;
		case (opc)
			adpe_pkg::OpAnd: logic_res = op1 & op2;
			adpe_pkg::OpEor: logic_res = op1 ^ op2;
			adpe_pkg::OpSub: arith = 1'b1;
			adpe_pkg::OpRsb: begin
				arith = 1'b1; add_a = op2; add_b = ~op1;
			end
			adpe_pkg::OpAdd: begin
				arith = 1'b1; add_b = op2; add_cin = 1'b0;
			end
			adpe_pkg::OpAdc: begin
				arith = 1'b1; add_b = op2; add_cin = c;
			end
			adpe_pkg::OpSbc: begin
				arith = 1'b1; add_cin = c;
			end
			adpe_pkg::OpRsc: begin
				arith = 1'b1; add_a = op2; add_b = ~op1; add_cin = c;
			end
			adpe_pkg::OpTst: begin
				compare = 1'b1; logic_res = op1 & op2;
			end
			adpe_pkg::OpTeq: begin
				compare = 1'b1; logic_res = op1 ^ op2;
			end
			adpe_pkg::OpCmp: begin
				arith = 1'b1; compare = 1'b1;
			end
			adpe_pkg::OpCmn: begin
				arith = 1'b1; compare = 1'b1; add_b = op2; add_cin = 1'b0;
			end
			adpe_pkg::OpOrr: logic_res = op1 | op2;
			adpe_pkg::OpMov: logic_res = op2;
			adpe_pkg::OpBic: logic_res = op1 & ~op2;
			default:         logic_res = ~op2;
		endcase
	end

	// Adder, result and flags
	always_comb begin
		sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
		value = arith ? sum[31:0] : logic_res;
		ovf   = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);
		upd   = instr_word[20] || compare;
		new_flags = flags;
		if (upd) begin
			new_flags[adpe_pkg::FlagN] = value[31];
			new_flags[adpe_pkg::FlagZ] = (value == 32'd0);
			new_flags[adpe_pkg::FlagC] = arith & sum[32];
			new_flags[adpe_pkg::FlagV] = arith & ovf;
		end
		res.passed    = passed;
		res.compare   = compare;
		res.flags_upd = passed && upd;
		res.result    = value;
		res.flags     = passed ? new_flags : flags;
	end

endmodule

// ===== src/arm_data_processing_execute.sv =====
// The input register takes the item at accept and the result register takes it at retire,
// which raises result_valid. Throughput: one item per cycle unless the result side stalls;
// input register, single-pass shift/ALU, result register.
// Register reads happen at accept with bypass from the item being retired that edge.
// Stalls on the result side back up through the input register one item at a time.
// Reset clears r0-r14 (by valid bits), the NZCV flags and both valid stages.
module arm_data_processing_execute (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     instr_valid,
	output logic                     instr_ready,
	input  adpe_pkg::instr_item_t    instr,
	output logic                     result_valid,
	input  logic                     result_ready,
	output adpe_pkg::result_item_t   result
);

	logic                    valid_s1;
	adpe_pkg::instr_item_t   item_s1;
	logic                    adv_s1;
	logic                    out_free;
	logic                    accept;
	logic [3:0]              flags_q;
	logic                    res_valid_q;
	adpe_pkg::result_item_t  res_q;
	adpe_pkg::rf_write_t     wb;
	adpe_pkg::alu_out_t      alu;
	adpe_pkg::result_item_t  res_next;
	logic [31:0] rn_raw, rm_raw, rs_raw;
	logic [31:0] pc_val;
	logic [31:0] op1, rm_val, rs_val, op2;
	logic [3:0]  rd;

	// Handshake
	assign out_free    = !res_valid_q || result_ready;
	assign adv_s1      = valid_s1 && out_free;
	assign instr_ready = !valid_s1 || out_free;
	assign accept      = instr_valid && instr_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr_ready) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= instr;
		end
	end

	// Register file, read at accept
	adpe_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rn_addr (instr.instr_word[19:16]),
		.rm_addr (instr.instr_word[3:0]),
		.rs_addr (instr.instr_word[11:8]),
		.wr      (wb),
		.rn_data (rn_raw),
		.rm_data (rm_raw),
		.rs_data (rs_raw)
	);

	// r15 reads give the address plus 8
	always_comb begin
		pc_val = item_s1.instr_addr + adpe_pkg::PcOffset;
		op1    = (item_s1.instr_word[19:16] == adpe_pkg::RegPc) ? pc_val : rn_raw;
		rm_val = (item_s1.instr_word[3:0] == adpe_pkg::RegPc) ? pc_val : rm_raw;
		rs_val = (item_s1.instr_word[11:8] == adpe_pkg::RegPc) ? pc_val : rs_raw;
	end

	adpe_operand2 u_operand2 (
		.instr_word (item_s1.instr_word),
		.rm_val     (rm_val),
		.rs_val     (rs_val),
		.op2        (op2)
	);

	adpe_alu u_alu (
		.instr_word (item_s1.instr_word),
		.op1        (op1),
		.op2        (op2),
		.flags      (flags_q),
		.res        (alu)
	);

	// Result item and write-back
	always_comb begin
		rd = item_s1.instr_word[15:12];
		res_next.cond_passed  = alu.passed;
		res_next.reg_written  = alu.passed && !alu.compare;
		res_next.dest_reg     = rd;
		res_next.alu_result   = alu.passed ? alu.result : 32'd0;
		res_next.flags_out    = alu.flags;
		res_next.branch_taken = alu.passed && !alu.compare && (rd == adpe_pkg::RegPc);
		wb.en   = adv_s1 && alu.passed && !alu.compare && (rd != adpe_pkg::RegPc);
		wb.addr = rd;
		wb.data = alu.result;
	end

	// Flags register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv_s1 && alu.flags_upd) begin
			flags_q <= alu.flags;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |-> wb.addr != adpe_pkg::RegPc)
		else $error("write-back to r15 reached the register file");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> result_valid)
		else $error("retired item did not reach the result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags_q))
		else $error("flags changed without a retiring item");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.branch_taken |->
			result.reg_written && result.dest_reg == adpe_pkg::RegPc)
		else $error("branch reported without a write to r15");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.cond_passed |->
			!result.reg_written && !result.branch_taken)
		else $error("skipped instruction reported a write");

endmodule
